// ----- rtl/tea_pkg.sv -----
// shared types, constants and helpers of the tea block cipher
`timescale 1ns / 1ps

package tea_pkg;

    localparam int unsigned CYCLE_COUNT = 32;
    localparam int unsigned STAGE_COUNT = 2 * CYCLE_COUNT;
    localparam logic [31:0] TEA_DELTA   = 32'h9e3779b9;
    localparam int unsigned ADDR_W      = 4;

    typedef enum logic [1:0] {
        REG_KEY_A = 2'd0,
        REG_KEY_B = 2'd1,
        REG_KEY_C = 2'd2,
        REG_KEY_D = 2'd3
    } reg_idx_t;

    localparam logic ACT_DECRYPT = 1'b1;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } key_t;

    typedef struct packed {
        logic        action;
        logic [31:0] left;
        logic [31:0] right;
    } blk_t;

    // delta times n, wrapped to 32 bits
    function automatic logic [31:0] tea_sum(input int unsigned n);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'(n);
        return prod[31:0];
    endfunction

endpackage

// ----- rtl/tea_block_cipher.sv -----
// tea block cipher top level: key registers and the half-round pipeline
// throughput: one item per cycle while the output is not stalled; 64 register stages, one per half-round
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset: rst_n is asynchronous, clears the key words to zero and empties the pipeline
`timescale 1ns / 1ps

module tea_block_cipher (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tea_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // input item channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      action,
    input  logic [31:0]               left_half_in,
    input  logic [31:0]               right_half_in,
    // result item channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [31:0]               left_half_out,
    output logic [31:0]               right_half_out
);
    import tea_pkg::*;

    key_t                   key;
    logic                   en;
    logic [STAGE_COUNT-1:0] vld;
    blk_t                   blk [STAGE_COUNT];
    blk_t                   blk_src;

    // key word registers behind the apb port
    tea_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key     (key)
    );

    // the last stage doubles as the output register; the pipe moves
    // as a whole whenever that register is empty or being taken
    assign en       = !vld[STAGE_COUNT-1] || out_ready;
    assign in_ready = en;

    assign blk_src.action = action;
    assign blk_src.left   = left_half_in;
    assign blk_src.right  = right_half_in;

    // stage s runs half-round s; its running sum is a constant per direction
    for (genvar s = 0; s < STAGE_COUNT; s++)
    begin : g_stage
        localparam int unsigned CYC   = s / 2;
        localparam logic        PHASE = 1'(s % 2);

        logic vld_src;
        blk_t blk_in;

        if (s == 0)
        begin : g_head
            assign vld_src = in_valid;
            assign blk_in  = blk_src;
        end
        else
        begin : g_body
            assign vld_src = vld[s-1];
            assign blk_in  = blk[s-1];
        end

        tea_hround u_hround (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .phase   (PHASE),
            .sum_enc (tea_sum(CYC + 1)),
            .sum_dec (tea_sum(CYCLE_COUNT - CYC)),
            .key     (key),
            .vld_in  (vld_src),
            .blk_in  (blk_in),
            .vld_out (vld[s]),
            .blk_out (blk[s])
        );
    end

    assign out_valid      = vld[STAGE_COUNT-1];
    assign left_half_out  = blk[STAGE_COUNT-1].left;
    assign right_half_out = blk[STAGE_COUNT-1].right;

    // a stall freezes every valid bit in the pipe
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(vld))
        else $error("pipeline valid bits moved during a stall");

    // an accepted item occupies the first stage on the next cycle
    a_accept_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld[0])
        else $error("accepted item missing from the first stage");

    // no item appears in the first stage without an accept
    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        (en && !in_valid) |=> !vld[0])
        else $error("item appeared without an accept");

    // an item in the second-to-last stage reaches the output when the pipe moves
    a_reach_out: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld[STAGE_COUNT-2]) |=> out_valid)
        else $error("item lost before the output register");

endmodule

// ----- rtl/tea_cfg.sv -----
// apb key register file
`timescale 1ns / 1ps

module tea_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tea_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output tea_pkg::key_t             key
);
    import tea_pkg::*;

    key_t     key_reg;
    key_t     key_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign key    = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_KEY_A: key_next.a = pwdata;
                REG_KEY_B: key_next.b = pwdata;
                REG_KEY_C: key_next.c = pwdata;
                REG_KEY_D: key_next.d = pwdata;
                default:   key_next   = key_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_KEY_A: prdata = key_reg.a;
            REG_KEY_B: prdata = key_reg.b;
            REG_KEY_C: prdata = key_reg.c;
            REG_KEY_D: prdata = key_reg.d;
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

endmodule

// ----- rtl/tea_hround.sv -----
// one half-round of tea with its pipeline register
`timescale 1ns / 1ps

module tea_hround (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          phase,
    input  logic [31:0]   sum_enc,
    input  logic [31:0]   sum_dec,
    input  tea_pkg::key_t key,
    input  logic          vld_in,
    input  tea_pkg::blk_t blk_in,
    output logic          vld_out,
    output tea_pkg::blk_t blk_out
);
    import tea_pkg::*;

    logic        vld_reg;
    logic        vld_next;
    blk_t        blk_reg;
    blk_t        blk_next;
    logic        dec;
    logic        upd_left;
    logic [31:0] v;
    logic [31:0] dst;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] sum;
    logic [31:0] mix;
    logic [31:0] res;

    // encrypt: even phase updates left, decrypt: odd phase updates left
    assign dec      = (blk_in.action == ACT_DECRYPT);
    assign upd_left = ~(phase ^ dec);
    assign v        = upd_left ? blk_in.right : blk_in.left;
    assign dst      = upd_left ? blk_in.left : blk_in.right;
    assign ka       = upd_left ? key.a : key.c;
    assign kb       = upd_left ? key.b : key.d;
    assign sum      = dec ? sum_dec : sum_enc;
    assign mix      = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    assign res      = dec ? (dst - mix) : (dst + mix);

    always_comb
    begin
        vld_next = vld_reg;
        blk_next = blk_reg;
        if (en)
        begin
            vld_next        = vld_in;
            blk_next.action = blk_in.action;
            blk_next.left   = upd_left ? res : blk_in.left;
            blk_next.right  = upd_left ? blk_in.right : res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

    assign vld_out = vld_reg;
    assign blk_out = blk_reg;

endmodule

// ----- test/tb_tea_block_cipher.sv -----
// self-checking testbench of the tea block cipher: directed and random blocks, both directions
`timescale 1ns / 1ps

module tb_tea_block_cipher;

    import tea_pkg::*;

    // encrypt code, the counterpart of the package's decrypt code
    localparam logic ACT_ENCRYPT = 1'b0;
    // cycles after the last result before the bench decides the run is over
    localparam int unsigned SETTLE_CYCLES = 80;
    // generous limit: about 2000 items, plus drains
    localparam int unsigned CYCLE_LIMIT = 600000;
    // random items per key setting and per idling stretch
    localparam int unsigned PHASE_ITEMS = 400;
    localparam int unsigned STRETCH_ITEMS = 50;

    // one result block, the two halves as they leave the block
    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
    } half_pair_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [31:0] left_half_in;
    logic [31:0] right_half_in;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] left_half_out;
    logic [31:0] right_half_out;

    // key words as the block should hold them
    key_t        key_shadow;
    // blocks still owed by the cipher, oldest first
    half_pair_t  pending_blocks[$];
    int unsigned error_count;
    int unsigned cycle_count;
    // idling switches, redrawn per stretch of items
    bit          sender_idles;
    bit          receiver_idles;
    // cycles the receiver still holds off before taking the next item
    int unsigned stall_left;

    tea_block_cipher i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .left_half_in   (left_half_in),
        .right_half_in  (right_half_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_half_out  (left_half_out),
        .right_half_out (right_half_out)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // --------------------------------------------------------------------
    // prediction
    // --------------------------------------------------------------------

    // one half-round mixing term: shifted copies of a half, each with a key word, and the half plus the sum
    function automatic logic [31:0] round_mix(input logic [31:0] v, input logic [31:0] s,
                                              input logic [31:0] ka, input logic [31:0] kb);
        return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
    endfunction

    // full cipher on one block under the given key, sums wrap at 32 bits
    function automatic half_pair_t tea_predict(input logic act, input logic [31:0] l,
                                               input logic [31:0] r, input key_t k);
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] s;
        half_pair_t  res;
        y = l;
        z = r;
        if (act == ACT_DECRYPT) begin
            // sum starts at delta times the cycle count, rounds run backwards
            s = TEA_DELTA * 32'(CYCLE_COUNT);
            for (int i = 0; i < CYCLE_COUNT; i++) begin
                z = z - round_mix(y, s, k.c, k.d);
                y = y - round_mix(z, s, k.a, k.b);
                s = s - TEA_DELTA;
            end
        end else begin
            s = '0;
            for (int i = 0; i < CYCLE_COUNT; i++) begin
                s = s + TEA_DELTA;
                y = y + round_mix(z, s, k.a, k.b);
                z = z + round_mix(y, s, k.c, k.d);
            end
        end
        res.left  = y;
        res.right = z;
        return res;
    endfunction

    // --------------------------------------------------------------------
    // result side: stalls and checking
    // --------------------------------------------------------------------

    // ready follows the stall count, changed on the falling edge only
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // every accepted result against the oldest owed block
    always @(posedge clk) begin
        half_pair_t exp_blk;
        if (rst_n && out_valid && out_ready) begin
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected result left %h right %h",
                         $time, left_half_out, right_half_out);
                error_count++;
            end else begin
                exp_blk = pending_blocks.pop_front();
                if (left_half_out !== exp_blk.left) begin
                    $display("%0t: left half mismatch, expected %h actual %h",
                             $time, exp_blk.left, left_half_out);
                    error_count++;
                end
                if (right_half_out !== exp_blk.right) begin
                    $display("%0t: right half mismatch, expected %h actual %h",
                             $time, exp_blk.right, right_half_out);
                    error_count++;
                end
            end
            // hold-off before the next result is taken
            stall_left = receiver_idles ? $urandom_range(0, 10) : 0;
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // --------------------------------------------------------------------
    // drivers
    // --------------------------------------------------------------------

    // register write then read-back over the configuration port
    task automatic write_key_word(input reg_idx_t idx, input logic [31:0] value);
        // setup phase of the write
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        // access phase, the word lands at the edge with pready high
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_KEY_A: key_shadow.a = value;
            REG_KEY_B: key_shadow.b = value;
            REG_KEY_C: key_shadow.c = value;
            REG_KEY_D: key_shadow.d = value;
            default:   ;
        endcase
        // back-to-back read of the same word
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value) begin
            $display("%0t: key word %s read-back, expected %h actual %h",
                     $time, idx.name(), value, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // whole key, only while the pipeline is empty
    task automatic load_key(input key_t k);
        write_key_word(REG_KEY_A, k.a);
        write_key_word(REG_KEY_B, k.b);
        write_key_word(REG_KEY_C, k.c);
        write_key_word(REG_KEY_D, k.d);
    endtask

    // one block in; valid stays up across back-to-back items
    task automatic send_block(input logic act, input logic [31:0] l, input logic [31:0] r);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, 10) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        left_half_in  <= l;
        right_half_in <= r;
        do @(posedge clk); while (!in_ready);
        pending_blocks.push_back(tea_predict(act, l, r, key_shadow));
    endtask

    // stop sending and let every owed result come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly plain random words, now and then an extreme
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // --------------------------------------------------------------------
    // tests
    // --------------------------------------------------------------------

    // reset key of all zeros, extreme and alternating blocks both ways
    task automatic test_reset_key();
        logic [31:0] pats[5];
        pats = '{32'h0000_0000, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h8000_0001};
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        for (int i = 0; i < 5; i++) begin
            send_block(ACT_ENCRYPT, pats[i], pats[4 - i]);
            send_block(ACT_DECRYPT, pats[i], pats[4 - i]);
        end
        wait_drained();
    endtask

    // all-ones key, then every word back to zero
    task automatic test_key_extremes();
        key_t k;
        k = '1;
        load_key(k);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        send_block(ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(ACT_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(ACT_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
        send_block(ACT_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
        wait_drained();
        k = '0;
        load_key(k);
        send_block(ACT_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
        wait_drained();
    endtask

    // decrypting a predicted ciphertext must give the plaintext back
    task automatic test_round_trip();
        key_t       k;
        half_pair_t ct;
        logic [31:0] pl;
        logic [31:0] pr;
        k = {$urandom, $urandom, $urandom, $urandom};
        load_key(k);
        for (int i = 0; i < 3; i++) begin
            pl = $urandom;
            pr = $urandom;
            ct = tea_predict(ACT_ENCRYPT, pl, pr, key_shadow);
            if (tea_predict(ACT_DECRYPT, ct.left, ct.right, key_shadow) !== {pl, pr}) begin
                $display("%0t: predictor round trip broken for %h %h", $time, pl, pr);
                error_count++;
            end
            send_block(ACT_ENCRYPT, pl, pr);
            send_block(ACT_DECRYPT, ct.left, ct.right);
        end
        wait_drained();
    endtask

    // long random traffic over several keys, idling switched per stretch
    task automatic test_random_traffic();
        key_t k;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                // alternating extremes across the four words
                0:       k = {32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000};
                1:       k = {32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff};
                default: k = {$urandom, $urandom, $urandom, $urandom};
            endcase
            load_key(k);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // new stretch: each side idles or runs flat out
                if (n % STRETCH_ITEMS == 0) begin
                    sender_idles   = ($urandom_range(0, 3) != 0);
                    receiver_idles = ($urandom_range(0, 3) != 0);
                end
                send_block(1'($urandom_range(0, 1)), pick_word(), pick_word());
            end
            wait_drained();
        end
    endtask

    // --------------------------------------------------------------------
    // sequence
    // --------------------------------------------------------------------

    initial begin
        // every input known from time zero
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        action         = ACT_ENCRYPT;
        left_half_in   = '0;
        right_half_in  = '0;
        out_ready      = 1'b1;
        stall_left     = 0;
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        key_shadow     = '0;
        error_count    = 0;
        cycle_count    = 0;

        // reset held low, released on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_key();
        test_key_extremes();
        test_round_trip();
        test_random_traffic();

        // anything still coming out now is a stray result
        receiver_idles = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
